### rtl/hsfd_pkg.sv
package hsfd_pkg;

	localparam int BYTE_W = 8;
	localparam int WORD_W = 16;
	localparam int TEMP_W = 15;
	localparam int HUM_W = 14;
	localparam int POS_W = 3;

	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
	localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

	localparam int TEMP_SCALE = 4375;
	localparam int TEMP_SHIFT = 14;
	localparam int TEMP_OFFSET = 4500;
	localparam int HUM_SCALE = 625;
	localparam int HUM_SHIFT = 12;

	localparam int TEMP_PROD_W = WORD_W + 13;
	localparam int HUM_PROD_W = WORD_W + 10;

	localparam logic [POS_W-1:0] POS_TEMP_MSB = 3'd0;
	localparam logic [POS_W-1:0] POS_TEMP_LSB = 3'd1;
	localparam logic [POS_W-1:0] POS_TEMP_CRC = 3'd2;
	localparam logic [POS_W-1:0] POS_HUM_MSB = 3'd3;
	localparam logic [POS_W-1:0] POS_HUM_LSB = 3'd4;
	localparam logic [POS_W-1:0] POS_HUM_CRC = 3'd5;

	typedef struct packed {
		logic hum_crc_bad;
		logic temp_crc_bad;
		logic [HUM_W-1:0] hum_centi;
		logic signed [TEMP_W-1:0] temp_centi;
	} result_t;

	function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
			input logic [BYTE_W-1:0] data);
		logic [BYTE_W-1:0] c;
		c = crc ^ data;
		for (int i = 0; i < BYTE_W; i++) begin
			if (c[BYTE_W-1]) begin
				c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[BYTE_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic logic signed [TEMP_W-1:0] temp_convert(input logic [WORD_W-1:0] raw);
		logic [TEMP_PROD_W-1:0] prod;
		logic [TEMP_W-1:0] scaled;
		prod = TEMP_PROD_W'(raw) * TEMP_PROD_W'(TEMP_SCALE);
		scaled = TEMP_W'(prod >> TEMP_SHIFT);
		return $signed(scaled - TEMP_W'(TEMP_OFFSET));
	endfunction

	function automatic logic [HUM_W-1:0] hum_convert(input logic [WORD_W-1:0] raw);
		logic [HUM_PROD_W-1:0] prod;
		prod = HUM_PROD_W'(raw) * HUM_PROD_W'(HUM_SCALE);
		return HUM_W'(prod >> HUM_SHIFT);
	endfunction

endpackage

### rtl/hsfd_frame.sv
module hsfd_frame (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [hsfd_pkg::BYTE_W-1:0] in_byte,
	input logic in_start,
	output logic res_valid,
	input logic res_ready,
	output hsfd_pkg::result_t res
);
	import hsfd_pkg::*;

	logic valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic start_s1;

	logic [POS_W-1:0] pos_q;
	logic [BYTE_W-1:0] crc_q;
	logic [BYTE_W-1:0] high_q;
	logic temp_bad_q;
	logic signed [TEMP_W-1:0] temp_conv_q;
	logic [HUM_W-1:0] hum_conv_q;
	logic signed [TEMP_W-1:0] good_temp_q;
	logic [HUM_W-1:0] good_hum_q;

	logic [POS_W-1:0] pos_eff;
	logic advance;
	logic [BYTE_W-1:0] crc_base;
	logic [BYTE_W-1:0] crc_next;
	logic [WORD_W-1:0] word;
	logic hum_bad;
	logic both_good;

	always_comb begin
		if (start_s1 || pos_q > POS_HUM_CRC) begin
			pos_eff = POS_TEMP_MSB;
		end else begin
			pos_eff = pos_q;
		end
	end

	assign res_valid = valid_s1 && (pos_eff == POS_HUM_CRC);
	assign advance = valid_s1 && (!res_valid || res_ready);
	assign in_ready = !valid_s1 || advance;

	assign crc_base = (pos_eff == POS_TEMP_MSB || pos_eff == POS_HUM_MSB) ? CRC_INIT : crc_q;
	assign crc_next = crc8_step(crc_base, byte_s1);
	assign word = {high_q, byte_s1};
	assign hum_bad = (byte_s1 != crc_q);
	assign both_good = !temp_bad_q && !hum_bad;

	assign res.temp_centi = both_good ? temp_conv_q : good_temp_q;
	assign res.hum_centi = both_good ? hum_conv_q : good_hum_q;
	assign res.temp_crc_bad = temp_bad_q;
	assign res.hum_crc_bad = hum_bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			start_s1 <= in_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_TEMP_MSB;
			crc_q <= CRC_INIT;
			high_q <= '0;
			temp_bad_q <= 1'b0;
			temp_conv_q <= temp_convert('0);
			hum_conv_q <= hum_convert('0);
			good_temp_q <= '0;
			good_hum_q <= '0;
		end else if (advance) begin
			unique case (pos_eff)
				POS_TEMP_MSB, POS_HUM_MSB: begin
					crc_q <= crc_next;
					high_q <= byte_s1;
					pos_q <= pos_eff + POS_W'(1);
				end
				POS_TEMP_LSB: begin
					crc_q <= crc_next;
					temp_conv_q <= temp_convert(word);
					pos_q <= POS_TEMP_CRC;
				end
				POS_TEMP_CRC: begin
					temp_bad_q <= (byte_s1 != crc_q);
					crc_q <= CRC_INIT;
					pos_q <= POS_HUM_MSB;
				end
				POS_HUM_LSB: begin
					crc_q <= crc_next;
					hum_conv_q <= hum_convert(word);
					pos_q <= POS_HUM_CRC;
				end
				default: begin
					if (both_good) begin
						good_temp_q <= temp_conv_q;
						good_hum_q <= hum_conv_q;
					end
					crc_q <= CRC_INIT;
					pos_q <= POS_TEMP_MSB;
				end
			endcase
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_HUM_CRC)
		else $error("Byte position left the reply.");

	a_result_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_valid) |=> (pos_q == POS_TEMP_MSB && crc_q == CRC_INIT))
		else $error("Reply end did not restart the position and CRC.");

	a_good_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_valid && !both_good) |=> $stable(good_temp_q) && $stable(good_hum_q))
		else $error("Stored values changed on a bad reply.");

endmodule

### rtl/hsfd_out.sv
module hsfd_out (
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	output logic res_ready,
	input hsfd_pkg::result_t res,
	output logic out_valid,
	input logic out_ready,
	output hsfd_pkg::result_t out_res
);
	import hsfd_pkg::*;

	logic valid_q;
	result_t res_q;

	assign res_ready = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

endmodule

### rtl/humidity_sensor_frame_decoder_core.sv
// Decodes the six-byte measurement reply of a temperature/humidity sensor, one byte per
// request on the slave side, and checks the CRC-8 (polynomial 0x31, init 0xFF) of each word.
// A new byte can be taken in every cycle unless the output register stalls the sixth byte; the
// CRC step and the scale multiply run between the input register and the state registers. The
// result is formed from the sixth byte in the input register and then waits in an output register.
// A set frame_start flag in tuser restarts the reply at that byte. Values not confirmed by both CRCs
// leave the last good temperature and humidity unchanged, and the error flags report why.
module humidity_sensor_frame_decoder_core (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [7:0] s_tdata, // rx_byte
	input logic [0:0] s_tuser, // frame_start
	output logic m_tvalid,
	input logic m_tready,
	output logic [31:0] m_tdata // temp_centi, hum_centi, temp_crc_bad, hum_crc_bad, zero pad
);
	import hsfd_pkg::*;

	logic res_valid;
	logic res_ready;
	result_t res;
	result_t out_res;

	hsfd_frame u_frame (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_byte(s_tdata),
		.in_start(s_tuser[0]),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	hsfd_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res(out_res)
	);

	assign m_tdata = {1'b0, out_res};

endmodule
